@@ rtl/core/gwm_pkg.sv @@
package gwm_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_SUBJECT = 2'd2,
        OP_END     = 2'd3
    } t_op;

    localparam logic [7:0] CH_ANY_RUN = 8'h2A;
    localparam logic [7:0] CH_ONE     = 8'h3F;

    typedef struct packed {
        t_op        op;
        logic [7:0] char_value;
    } t_item;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_result;

endpackage

@@ rtl/core/gwm_in_stage.sv @@
module gwm_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_opcode,
    input  logic [7:0]    i_char_value,
    input  logic          i_advance,
    output logic          o_item_valid,
    output gwm_pkg::t_item o_item
);

    logic           r_valid;
    gwm_pkg::t_item r_item;
    logic           n_load;

    // register is free when empty or when its item moves on this cycle
    assign n_load  = !r_valid || i_advance;
    assign o_stall = !n_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load && i_valid) begin
            r_item.op         <= gwm_pkg::t_op'(i_opcode);
            r_item.char_value <= i_char_value;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

@@ rtl/core/gwm_nfa.sv @@
module gwm_nfa #(
    parameter int MAX_PATTERN = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  gwm_pkg::t_item   i_item,
    output gwm_pkg::t_result o_result
);

    localparam int NPOS = MAX_PATTERN + 1;

    logic [7:0]             r_store [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_is_star;
    logic [MAX_PATTERN-1:0] r_is_one;
    logic [MAX_PATTERN-1:0] r_len_mask;   // thermometer of the pattern length
    logic [NPOS-1:0]        r_end;        // one-hot: position equal to the length
    logic [NPOS-1:0]        r_active;
    logic                   r_ovf;

    logic [MAX_PATTERN-1:0] n_len_mask;
    logic [NPOS-1:0]        n_end;
    logic [NPOS-1:0]        n_active;
    logic                   n_ovf;

    logic [MAX_PATTERN-1:0] star;
    logic [MAX_PATTERN-1:0] seed;
    logic [NPOS-1:0]        carry_sum;
    logic [NPOS-1:0]        closed;
    logic [MAX_PATTERN-1:0] step;

    // Star closure as a carry chain: an active star launches a carry that
    // runs across the following stars and lands on the first non-star.
    assign star      = r_is_star & r_len_mask;
    assign seed      = r_active[MAX_PATTERN-1:0] & star;
    assign carry_sum = {1'b0, star} + {1'b0, seed};
    assign closed    = r_active | (carry_sum ^ {1'b0, star});

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            step[i] = closed[i] & r_len_mask[i] & ~r_is_star[i]
                    & (r_is_one[i] | (r_store[i] == i_item.char_value));
        end
    end

    assign o_result.matched  = (|(closed & r_end)) & ~r_ovf;
    assign o_result.overflow = r_ovf;

    always_comb begin
        n_len_mask = r_len_mask;
        n_end      = r_end;
        n_ovf      = r_ovf;
        n_active   = r_active;
        if (i_fire) begin
            case (i_item.op)
                gwm_pkg::OP_CLEAR: begin
                    n_len_mask = '0;
                    n_end      = NPOS'(1);
                    n_ovf      = 1'b0;
                    n_active   = NPOS'(1);
                end
                gwm_pkg::OP_APPEND: begin
                    if (r_end[MAX_PATTERN]) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len_mask = r_len_mask | r_end[MAX_PATTERN-1:0];
                        n_end      = {r_end[NPOS-2:0], 1'b0};
                    end
                    n_active = NPOS'(1);
                end
                gwm_pkg::OP_SUBJECT: begin
                    n_active = {1'b0, closed[MAX_PATTERN-1:0] & star} | {step, 1'b0};
                end
                gwm_pkg::OP_END: begin
                    n_active = NPOS'(1);
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_mask <= '0;
            r_end      <= NPOS'(1);
            r_ovf      <= 1'b0;
            r_active   <= NPOS'(1);
        end else begin
            r_len_mask <= n_len_mask;
            r_end      <= n_end;
            r_ovf      <= n_ovf;
            r_active   <= n_active;
        end
    end

    // pattern bytes land at the current end position
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i_fire && i_item.op == gwm_pkg::OP_APPEND && r_end[i]) begin
                r_store[i]   <= i_item.char_value;
                r_is_star[i] <= (i_item.char_value == gwm_pkg::CH_ANY_RUN);
                r_is_one[i]  <= (i_item.char_value == gwm_pkg::CH_ONE);
            end
        end
    end

endmodule

@@ rtl/core/glob_wildcard_matcher_top.sv @@
// Flow: an end-of-subject item is registered in the input stage, then its result
//   is registered in the output register and shown on o_valid.
// Throughput: one item per cycle, but an end item waits while the output
//   is full and stalled; NFA: carry-chain star closure, per-position compare.
// Reset (synchronous, active low): empty pattern, overflow cleared, position 0
//   active, no item in flight; pattern byte contents are not reset.
module glob_wildcard_matcher_top #(
    parameter int MAX_PATTERN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_char_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_matched,
    output logic       o_pattern_overflow
);

    logic             s1_valid;
    gwm_pkg::t_item   s1_item;
    logic             advance;
    logic             fire;
    gwm_pkg::t_result result;

    logic             r_out_valid;
    logic             r_matched;
    logic             r_ovf;

    // only an end item needs the output register to be free
    assign advance = (s1_item.op != gwm_pkg::OP_END) || !r_out_valid || !i_stall;
    assign fire    = s1_valid && advance;

    gwm_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_char_value (i_char_value),
        .i_advance    (advance),
        .o_item_valid (s1_valid),
        .o_item       (s1_item)
    );

    gwm_nfa #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_nfa (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (s1_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && s1_item.op == gwm_pkg::OP_END) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && s1_item.op == gwm_pkg::OP_END) begin
            r_matched <= result.matched;
            r_ovf     <= result.overflow;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_matched          = r_matched;
    assign o_pattern_overflow = r_ovf;

`ifndef SYNTH
    a_no_match_on_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_matched && o_pattern_overflow))
        else $error("match reported with pattern overflow");

    a_end_blocked_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && s1_item.op == gwm_pkg::OP_END && r_out_valid && i_stall) |-> o_stall)
        else $error("input taken while end result is blocked");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && s1_item.op == gwm_pkg::OP_END) |=> o_valid)
        else $error("end item produced no result");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_PAT    = 32;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 80;
    localparam int RAND_ITEMS = 650;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_opcode;
    logic [7:0] i_char_value;
    logic       o_valid;
    logic       i_stall;
    logic       o_matched;
    logic       o_pattern_overflow;

    glob_wildcard_matcher_top #(.MAX_PATTERN(MAX_PAT)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_char_value       (i_char_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_matched          (o_matched),
        .o_pattern_overflow (o_pattern_overflow)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [7:0]      pat_mem [MAX_PAT];
    int              pat_len;
    logic [MAX_PAT:0] act_pos;
    bit              ovf_flag;

    gwm_pkg::t_result match_q [$];
    logic [7:0] pat_q [$];   // pattern bytes as stored (first MAX_PAT)

    int n_fail;
    int n_rand;
    int snd_idle_pct;
    int rcv_stall_pct;
    bit hold_req;
    bit hold_taken;
    int hold_left;
    int idle_cycles;

    typedef struct packed {
        gwm_pkg::t_op op;
        logic [7:0]   ch;
        logic         typed;
        logic         exp_m;
        logic         exp_o;
    } t_row;

    t_row dir_rows [0:24] = '{
        '{gwm_pkg::OP_END,     8'h00,               1'b1, 1'b1, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_END,     8'hFF,               1'b1, 1'b0, 1'b0},
        '{gwm_pkg::OP_APPEND,  8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_APPEND,  8'hFF,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'hFF,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_END,     8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_APPEND,  gwm_pkg::CH_ANY_RUN, 1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'hFF,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_END,     8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_APPEND,  8'h41,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'hFF,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'h41,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_END,     8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_CLEAR,   8'hFF,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_APPEND,  gwm_pkg::CH_ONE,     1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_END,     8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_SUBJECT, 8'h7E,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_END,     8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_CLEAR,   8'h00,               1'b0, 1'b0, 1'b0},
        '{gwm_pkg::OP_END,     8'h00,               1'b1, 1'b1, 1'b0}
    };

    // a star position may match empty, so activity runs forward across stars
    function automatic void close_star_runs();
        for (int i = 0; i < MAX_PAT; i++) begin
            if (i < pat_len && act_pos[i] && pat_mem[i] == gwm_pkg::CH_ANY_RUN)
                act_pos[i+1] = 1'b1;
        end
    endfunction

    function automatic void glob_step(input gwm_pkg::t_op op, input logic [7:0] ch,
                                      output bit has_res, output gwm_pkg::t_result res);
        logic [MAX_PAT:0] nxt;
        has_res = 1'b0;
        res     = '0;
        nxt     = '0;
        case (op)
            gwm_pkg::OP_CLEAR: begin
                pat_len  = 0;
                ovf_flag = 1'b0;
                act_pos  = (MAX_PAT+1)'(1);
            end
            gwm_pkg::OP_APPEND: begin
                if (pat_len >= MAX_PAT) begin
                    ovf_flag = 1'b1;
                end else begin
                    pat_mem[pat_len] = ch;
                    pat_len++;
                end
                act_pos = (MAX_PAT+1)'(1);
            end
            gwm_pkg::OP_SUBJECT: begin
                close_star_runs();
                for (int i = 0; i < MAX_PAT; i++) begin
                    if (i < pat_len && act_pos[i]) begin
                        if (pat_mem[i] == gwm_pkg::CH_ANY_RUN)
                            nxt[i] = 1'b1;
                        else if (pat_mem[i] == gwm_pkg::CH_ONE || pat_mem[i] == ch)
                            nxt[i+1] = 1'b1;
                    end
                end
                act_pos = nxt;
            end
            default: begin
                close_star_runs();
                res.matched  = act_pos[pat_len] && !ovf_flag;
                res.overflow = ovf_flag;
                has_res      = 1'b1;
                act_pos      = (MAX_PAT+1)'(1);
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(9))
            0, 1, 2: return 8'h61;
            3:       return 8'h62;
            4, 5:    return gwm_pkg::CH_ANY_RUN;
            6:       return gwm_pkg::CH_ONE;
            7:       return 8'h00;
            8:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input gwm_pkg::t_op op, input logic [7:0] ch,
                             input bit typed, input gwm_pkg::t_result typed_res);
        bit               has_res;
        gwm_pkg::t_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_char_value <= ch;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        glob_step(op, ch, has_res, res);
        if (has_res)
            match_q.push_back(typed ? typed_res : res);
        if (op == gwm_pkg::OP_CLEAR)
            pat_q.delete();
        else if (op == gwm_pkg::OP_APPEND && pat_q.size() < MAX_PAT)
            pat_q.push_back(ch);
    endtask

    task automatic send_rand(input gwm_pkg::t_op op, input logic [7:0] ch);
        send_item(op, ch, 1'b0, '0);
        n_rand++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
    endtask

    // mostly well-formed subjects built from the current pattern, some mutated
    task automatic run_random(input int stop_at);
        logic [7:0] subj [$];
        int         r;
        int         plen;
        int         idx;
        while (n_rand < stop_at) begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_rand(gwm_pkg::OP_CLEAR, 8'($urandom_range(255)));
                r = $urandom_range(99);
                plen = (r < 70) ? $urandom_range(6) :
                       (r < 85) ? $urandom_range(32, 30) : $urandom_range(35, 33);
                repeat (plen) send_rand(gwm_pkg::OP_APPEND, pick_char());
            end else if (r < 18) begin
                send_rand(gwm_pkg::t_op'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                subj.delete();
                foreach (pat_q[k]) begin
                    if (pat_q[k] == gwm_pkg::CH_ANY_RUN)
                        repeat ($urandom_range(3)) subj.push_back(pick_char());
                    else if (pat_q[k] == gwm_pkg::CH_ONE)
                        subj.push_back(pick_char());
                    else
                        subj.push_back(pat_q[k]);
                end
                if ($urandom_range(3) == 0) begin
                    idx = (subj.size() > 0) ? $urandom_range(subj.size() - 1) : 0;
                    case ($urandom_range(2))
                        0: if (subj.size() > 0) subj[idx] = 8'($urandom_range(255));
                        1: if (subj.size() > 0) subj.delete(idx);
                        default: subj.insert(idx, pick_char());
                    endcase
                end
                foreach (subj[k]) begin
                    if ($urandom_range(49) == 0)
                        send_rand(gwm_pkg::OP_APPEND, pick_char());
                    send_rand(gwm_pkg::OP_SUBJECT, subj[k]);
                end
                send_rand(gwm_pkg::OP_END, 8'($urandom_range(255)));
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_LEN - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (match_q.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    n_fail++;
                end else begin
                    if (o_matched !== match_q[0].matched) begin
                        $error("matched: expected %0b, actual %0b",
                               match_q[0].matched, o_matched);
                        n_fail++;
                    end
                    if (o_pattern_overflow !== match_q[0].overflow) begin
                        $error("pattern_overflow: expected %0b, actual %0b",
                               match_q[0].overflow, o_pattern_overflow);
                        n_fail++;
                    end
                    void'(match_q.pop_front());
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        gwm_pkg::t_result tr;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = gwm_pkg::OP_CLEAR;
        i_char_value  = 8'h00;
        i_stall       = 1'b0;
        n_fail        = 0;
        n_rand        = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_req      = 1'b0;
        hold_taken    = 1'b0;
        hold_left     = 0;
        idle_cycles   = 0;
        pat_len       = 0;
        ovf_flag      = 1'b0;
        act_pos       = (MAX_PAT+1)'(1);
        foreach (pat_mem[k]) pat_mem[k] = 8'h00;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            tr.matched  = dir_rows[k].exp_m;
            tr.overflow = dir_rows[k].exp_o;
            send_item(dir_rows[k].op, dir_rows[k].ch, dir_rows[k].typed, tr);
        end
        drain();

        // full-speed phase with one long receiver hold-off; the burst of
        // end items backs the block up so it has to stall its input
        hold_req = 1'b1;
        repeat (30) send_rand(gwm_pkg::OP_END, 8'($urandom_range(255)));
        run_random(80);
        drain();

        run_random(230);
        drain();

        snd_idle_pct = 60;
        run_random(370);
        drain();

        snd_idle_pct  = 0;
        rcv_stall_pct = 60;
        run_random(510);
        drain();

        snd_idle_pct  = 29;
        rcv_stall_pct = 29;
        run_random(RAND_ITEMS);
        drain();

        repeat (10) @(posedge i_clk);
        if (n_fail == 0 && match_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
